/* rtl/amha_pkg.sv */
// Shared widths, constants and handoff types for the accelerometer Hull average block.
package amha_pkg;

    localparam int STAMP_W     = 32;
    localparam int AXIS_W      = 16;
    localparam int MAG_W       = 16;
    localparam int DIFF_W      = 18;
    localparam int HULL_W      = 18;
    localparam int SUM_W       = 32;
    localparam int ROOT_STEPS  = SUM_W / 2;
    localparam int QUEUE_DEPTH = 2;

    // Largest magnitude: floor sqrt of 3 * 32768^2
    localparam logic [MAG_W-1:0] MAG_MAX = 16'd56755;

    // One magnitude item handed from the front end to the filter
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [MAG_W-1:0]   magnitude;
    } item_t;

    // Queue occupancy seen by both sides
    typedef struct packed {
        logic full;
        logic not_empty;
    } qstat_t;

endpackage

/* rtl/accel_magnitude_hull_average_unit.sv */
// Top level: accelerometer magnitude followed by a Hull moving average.
//
//  Channel   Handshake                   Payload
//  sample    sample_valid / sample_stall stamp, accel_x, accel_y, accel_z
//  result    result_valid / result_stall stamp_out, magnitude, hull_value
//
// The front end accepts a sample, squares and sums the axes on one multiplier,
// runs the bit-pair square root and hands off the item; it stalls new samples
// until the handoff. The filter takes one item at a time from the queue and runs
// two prefix-sum passes on it, the weighted averages and the Hull combination.
// A two-entry queue lets the front end keep working while the filter or the
// result register stalls. Reset clears the fill count; each window is refilled
// before its average is used.
module accel_magnitude_hull_average_unit
#(
    parameter int LONG_WINDOW  = 10,
    parameter int SHORT_WINDOW = 5,
    parameter int FINAL_WINDOW = 3
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic        [amha_pkg::STAMP_W-1:0] stamp,
    input  logic signed [amha_pkg::AXIS_W-1:0]  accel_x,
    input  logic signed [amha_pkg::AXIS_W-1:0]  accel_y,
    input  logic signed [amha_pkg::AXIS_W-1:0]  accel_z,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic        [amha_pkg::STAMP_W-1:0] stamp_out,
    output logic        [amha_pkg::MAG_W-1:0]   magnitude,
    output logic signed [amha_pkg::HULL_W-1:0]  hull_value
);

    amha_pkg::qstat_t  q_stat;
    amha_pkg::item_t   q_push_item;
    amha_pkg::item_t   q_head;
    logic              q_push;
    logic              q_pop;

    amha_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .stamp        (stamp),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .qstat        (q_stat),
        .push         (q_push),
        .push_item    (q_push_item)
    );

    amha_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .head      (q_head),
        .qstat     (q_stat)
    );

    amha_back
    #(
        .LONG_WINDOW  (LONG_WINDOW),
        .SHORT_WINDOW (SHORT_WINDOW),
        .FINAL_WINDOW (FINAL_WINDOW)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (q_stat),
        .head         (q_head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stamp_out    (stamp_out),
        .magnitude    (magnitude),
        .hull_value   (hull_value)
    );

`ifndef SYNTHESIS
    // Front end goes busy right after taking a sample
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("front end not busy after accepting an item");

    // Never write into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    // Never read from an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.not_empty)
        else $error("pop from empty queue");

    // Square root result stays within the reachable range
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_push_item.magnitude <= amha_pkg::MAG_MAX)
        else $error("magnitude out of range");
`endif

endmodule

/* rtl/amha_front.sv */
// Front end: accepts samples, sums squared axes and takes the integer square root.
module amha_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic        [amha_pkg::STAMP_W-1:0]  stamp,
    input  logic signed [amha_pkg::AXIS_W-1:0]   accel_x,
    input  logic signed [amha_pkg::AXIS_W-1:0]   accel_y,
    input  logic signed [amha_pkg::AXIS_W-1:0]   accel_z,
    input  amha_pkg::qstat_t                     qstat,
    output logic                                 push,
    output amha_pkg::item_t                      push_item
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SQR  = 2'd1;
    localparam logic [1:0] F_ROOT = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    localparam int STEP_W = $clog2(amha_pkg::ROOT_STEPS);
    localparam int REM_W  = amha_pkg::MAG_W + 1;
    localparam logic [STEP_W-1:0] SQR_LAST  = STEP_W'(2);
    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(amha_pkg::ROOT_STEPS - 1);

    logic [1:0]                          state_reg, state_next;
    logic [STEP_W-1:0]                   step_reg, step_next;
    logic [amha_pkg::STAMP_W-1:0]        stamp_reg;
    logic signed [amha_pkg::AXIS_W-1:0]  axis_reg [3];
    logic [amha_pkg::SUM_W-1:0]          sum_reg;
    logic [amha_pkg::MAG_W-1:0]          root_reg;
    logic [REM_W-1:0]                    rem_reg;

    logic signed [amha_pkg::SUM_W-1:0]   square;
    logic [REM_W+1:0]                    rem_shift;
    logic [REM_W+1:0]                    trial;
    logic [REM_W+1:0]                    rem_diff;
    logic                                take_bit;
    logic                                accept;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != F_IDLE);
    assign push         = (state_reg == F_PUSH) && !qstat.full;
    assign push_item    = '{stamp: stamp_reg, magnitude: root_reg};

    // Square one axis per cycle
    assign square = axis_reg[0] * axis_reg[0];

    // One restoring square-root step: two radicand bits in, one root bit out
    assign rem_shift = {rem_reg, sum_reg[amha_pkg::SUM_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign take_bit  = (rem_shift >= trial);
    assign rem_diff  = rem_shift - trial;

    // Sequence the item through squaring, root and handoff
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    state_next = F_SQR;
                end
            end
            F_SQR:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == SQR_LAST)
                begin
                    step_next  = '0;
                    state_next = F_ROOT;
                end
            end
            F_ROOT:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == ROOT_LAST)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!qstat.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Capture the sample, accumulate squares, then advance the root
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stamp_reg   <= stamp;
            axis_reg[0] <= accel_x;
            axis_reg[1] <= accel_y;
            axis_reg[2] <= accel_z;
            sum_reg     <= '0;
            root_reg    <= '0;
            rem_reg     <= '0;
        end
        else if (state_reg == F_SQR)
        begin
            axis_reg[0] <= axis_reg[1];
            axis_reg[1] <= axis_reg[2];
            sum_reg     <= sum_reg + unsigned'(square);
        end
        else if (state_reg == F_ROOT)
        begin
            sum_reg  <= {sum_reg[amha_pkg::SUM_W-3:0], 2'b00};
            root_reg <= {root_reg[amha_pkg::MAG_W-2:0], take_bit};
            rem_reg  <= take_bit ? rem_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
        end
    end

endmodule

/* rtl/amha_queue.sv */
// Two-entry queue that decouples the magnitude front end from the filter.
module amha_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  amha_pkg::item_t   push_item,
    input  logic              pop,
    output amha_pkg::item_t   head,
    output amha_pkg::qstat_t  qstat
);

    localparam int PTR_W = $clog2(amha_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(amha_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(amha_pkg::QUEUE_DEPTH);

    amha_pkg::item_t   entry_reg [amha_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign head            = entry_reg[rd_ptr_reg];
    assign qstat.full      = (count_reg == FULL_CNT);
    assign qstat.not_empty = (count_reg != '0);

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/amha_back.sv */
// Filter back end: weighted averages, Hull combination and the result register.
module amha_back
#(
    parameter int LONG_WINDOW  = 10,
    parameter int SHORT_WINDOW = 5,
    parameter int FINAL_WINDOW = 3
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  amha_pkg::qstat_t                    qstat,
    input  amha_pkg::item_t                     head,
    output logic                                pop,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic        [amha_pkg::STAMP_W-1:0] stamp_out,
    output logic        [amha_pkg::MAG_W-1:0]   magnitude,
    output logic signed [amha_pkg::HULL_W-1:0]  hull_value
);

    localparam int MAG_W  = amha_pkg::MAG_W;
    localparam int DIFF_W = amha_pkg::DIFF_W;
    localparam int HULL_W = amha_pkg::HULL_W;

    localparam int MAG_DEPTH = (LONG_WINDOW > SHORT_WINDOW) ? LONG_WINDOW : SHORT_WINDOW;
    localparam int LOOP_N    = (MAG_DEPTH > FINAL_WINDOW) ? MAG_DEPTH : FINAL_WINDOW;
    localparam int CNT_W     = $clog2(LOOP_N + 1);
    localparam int MI_W      = $clog2(MAG_DEPTH);

    localparam int TOT_L = LONG_WINDOW * (LONG_WINDOW + 1) / 2;
    localparam int TOT_S = SHORT_WINDOW * (SHORT_WINDOW + 1) / 2;
    localparam int TOT_F = FINAL_WINDOW * (FINAL_WINDOW + 1) / 2;

    localparam int PRE_W   = MAG_W + $clog2(MAG_DEPTH + 1);
    localparam int ACC_L_W = MAG_W + $clog2(TOT_L + 1);
    localparam int ACC_S_W = MAG_W + $clog2(TOT_S + 1);
    localparam int PF_W    = DIFF_W + $clog2(FINAL_WINDOW + 1);
    localparam int ACC_F_W = DIFF_W + $clog2(TOT_F + 1);
    localparam int DIV_LS  = (ACC_L_W > ACC_S_W) ? ACC_L_W : ACC_S_W;
    localparam int DIV_W   = (DIV_LS > ACC_F_W) ? DIV_LS : ACC_F_W;
    localparam int M_W     = DIV_W + 1;
    localparam int PROD_W  = DIV_W + M_W;

    // Reciprocals: floor(n / T) = (n * ceil(2^SH / T)) >> SH for n below 2^DIV_W
    localparam int SH_L = DIV_W + $clog2(TOT_L);
    localparam int SH_S = DIV_W + $clog2(TOT_S);
    localparam int SH_F = DIV_W + $clog2(TOT_F);
    localparam logic [63:0] M_L_FULL = ((64'd1 << SH_L) + 64'(TOT_L) - 64'd1) / 64'(TOT_L);
    localparam logic [63:0] M_S_FULL = ((64'd1 << SH_S) + 64'(TOT_S) - 64'd1) / 64'(TOT_S);
    localparam logic [63:0] M_F_FULL = ((64'd1 << SH_F) + 64'(TOT_F) - 64'd1) / 64'(TOT_F);
    localparam logic [M_W-1:0] M_L = M_L_FULL[M_W-1:0];
    localparam logic [M_W-1:0] M_S = M_S_FULL[M_W-1:0];
    localparam logic [M_W-1:0] M_F = M_F_FULL[M_W-1:0];

    localparam logic [CNT_W-1:0] L_CNT    = CNT_W'(LONG_WINDOW);
    localparam logic [CNT_W-1:0] S_CNT    = CNT_W'(SHORT_WINDOW);
    localparam logic [CNT_W-1:0] F_CNT    = CNT_W'(FINAL_WINDOW);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(LOOP_N);
    localparam logic [CNT_W-1:0] MAG_LAST = CNT_W'(MAG_DEPTH - 1);
    localparam logic [CNT_W-1:0] FIN_LAST = CNT_W'(FINAL_WINDOW - 1);

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_MAG   = 4'd1;
    localparam logic [3:0] B_MUL_S = 4'd2;
    localparam logic [3:0] B_MUL_L = 4'd3;
    localparam logic [3:0] B_DIFF  = 4'd4;
    localparam logic [3:0] B_FIN   = 4'd5;
    localparam logic [3:0] B_MUL_F = 4'd6;
    localparam logic [3:0] B_HULL  = 4'd7;
    localparam logic [3:0] B_OUT   = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]  seen_reg, seen_next;
    logic              res_valid_reg, res_valid_next;

    logic [MAG_W-1:0]                 mag_hist_reg [MAG_DEPTH];
    logic signed [DIFF_W-1:0]         diff_hist_reg [FINAL_WINDOW];
    logic signed [DIFF_W-1:0]         fin_work_reg [FINAL_WINDOW];
    logic [amha_pkg::STAMP_W-1:0]     stamp_reg;
    logic [MAG_W-1:0]                 mag_reg;
    logic [PRE_W-1:0]                 pre_reg;
    logic [ACC_L_W-1:0]               acc_l_reg;
    logic [ACC_S_W-1:0]               acc_s_reg;
    logic signed [PF_W-1:0]           pre_f_reg;
    logic signed [ACC_F_W-1:0]        acc_f_reg;
    logic                             neg_reg;
    logic [PROD_W-1:0]                prod_reg;
    logic [MAG_W-1:0]                 short_reg;
    logic signed [DIFF_W-1:0]         diff_reg;
    logic signed [HULL_W-1:0]         hull_reg;
    logic [amha_pkg::STAMP_W-1:0]     stamp_out_reg;
    logic [MAG_W-1:0]                 mag_out_reg;
    logic signed [HULL_W-1:0]         hull_out_reg;

    logic [PRE_W-1:0]          pre_next;
    logic signed [PF_W-1:0]    pre_f_next;
    logic [ACC_F_W-1:0]        acc_f_abs;
    logic [DIV_W-1:0]          mul_a;
    logic [M_W-1:0]            mul_m;
    logic [PROD_W-1:0]         prod_next;
    logic [PROD_W-1:0]         shr_s, shr_l, shr_f;
    logic [MAG_W-1:0]          short_next, long_val;
    logic signed [DIFF_W-1:0]  diff_next;
    logic [HULL_W-1:0]         fin_q;
    logic signed [HULL_W-1:0]  hull_next;
    logic                      out_free;

    assign pop          = (state_reg == B_IDLE) && qstat.not_empty;
    assign out_free     = !res_valid_reg || !result_stall;
    assign result_valid = res_valid_reg;
    assign stamp_out    = stamp_out_reg;
    assign magnitude    = mag_out_reg;
    assign hull_value   = hull_out_reg;

    // Running prefix sums: adding the prefix each step gives weights w..1
    assign pre_next   = pre_reg + PRE_W'(mag_hist_reg[step_reg[MI_W-1:0]]);
    assign pre_f_next = pre_f_reg + PF_W'(fin_work_reg[0]);

    // Shared reciprocal multiplier, operands picked by state
    assign acc_f_abs = acc_f_reg[ACC_F_W-1] ? ~acc_f_reg : acc_f_reg;
    always_comb
    begin
        mul_a = '0;
        mul_m = '0;
        case (state_reg)
            B_MUL_S:
            begin
                mul_a = DIV_W'(acc_s_reg);
                mul_m = M_S;
            end
            B_MUL_L:
            begin
                mul_a = DIV_W'(acc_l_reg);
                mul_m = M_L;
            end
            B_MUL_F:
            begin
                mul_a = DIV_W'(acc_f_abs);
                mul_m = M_F;
            end
            default:
            begin
                mul_a = '0;
                mul_m = '0;
            end
        endcase
    end
    assign prod_next = mul_a * mul_m;

    // Quotients, with raw passthrough until a window has filled
    assign shr_s      = prod_reg >> SH_S;
    assign shr_l      = prod_reg >> SH_L;
    assign shr_f      = prod_reg >> SH_F;
    assign short_next = (seen_reg >= S_CNT) ? shr_s[MAG_W-1:0] : mag_reg;
    assign long_val   = (seen_reg >= L_CNT) ? shr_l[MAG_W-1:0] : mag_reg;
    assign diff_next  = signed'({1'b0, short_reg, 1'b0}) - signed'({2'b00, long_val});

    // Negative sums divide as ~floor(~n / T), which rounds toward minus infinity
    assign fin_q     = shr_f[HULL_W-1:0];
    assign hull_next = (seen_reg >= F_CNT) ? signed'(neg_reg ? ~fin_q : fin_q) : diff_reg;

    // Step through the filter one item at a time
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        seen_next      = seen_reg;
        res_valid_next = res_valid_reg && result_stall;
        unique case (state_reg)
            B_IDLE:
            begin
                step_next = '0;
                if (qstat.not_empty)
                begin
                    state_next = B_MAG;
                    if (seen_reg < CAP_CNT)
                    begin
                        seen_next = seen_reg + CNT_W'(1);
                    end
                end
            end
            B_MAG:
            begin
                step_next = step_reg + CNT_W'(1);
                if (step_reg == MAG_LAST)
                begin
                    state_next = B_MUL_S;
                end
            end
            B_MUL_S:
            begin
                state_next = B_MUL_L;
            end
            B_MUL_L:
            begin
                state_next = B_DIFF;
            end
            B_DIFF:
            begin
                step_next  = '0;
                state_next = B_FIN;
            end
            B_FIN:
            begin
                step_next = step_reg + CNT_W'(1);
                if (step_reg == FIN_LAST)
                begin
                    state_next = B_MUL_F;
                end
            end
            B_MUL_F:
            begin
                state_next = B_HULL;
            end
            B_HULL:
            begin
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            seen_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            seen_reg      <= seen_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath: histories, accumulators, product and result register
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (qstat.not_empty)
                begin
                    stamp_reg       <= head.stamp;
                    mag_reg         <= head.magnitude;
                    mag_hist_reg[0] <= head.magnitude;
                    for (int i = 1; i < MAG_DEPTH; i++)
                    begin
                        mag_hist_reg[i] <= mag_hist_reg[i-1];
                    end
                    pre_reg   <= '0;
                    acc_l_reg <= '0;
                    acc_s_reg <= '0;
                end
            end
            B_MAG:
            begin
                pre_reg <= pre_next;
                if (step_reg < L_CNT)
                begin
                    acc_l_reg <= acc_l_reg + ACC_L_W'(pre_next);
                end
                if (step_reg < S_CNT)
                begin
                    acc_s_reg <= acc_s_reg + ACC_S_W'(pre_next);
                end
            end
            B_MUL_S:
            begin
                prod_reg <= prod_next;
            end
            B_MUL_L:
            begin
                short_reg <= short_next;
                prod_reg  <= prod_next;
            end
            B_DIFF:
            begin
                diff_reg         <= diff_next;
                diff_hist_reg[0] <= diff_next;
                fin_work_reg[0]  <= diff_next;
                for (int i = 1; i < FINAL_WINDOW; i++)
                begin
                    diff_hist_reg[i] <= diff_hist_reg[i-1];
                    fin_work_reg[i]  <= diff_hist_reg[i-1];
                end
                pre_f_reg <= '0;
                acc_f_reg <= '0;
            end
            B_FIN:
            begin
                pre_f_reg <= pre_f_next;
                acc_f_reg <= acc_f_reg + ACC_F_W'(pre_f_next);
                for (int i = 0; i < FINAL_WINDOW - 1; i++)
                begin
                    fin_work_reg[i] <= fin_work_reg[i+1];
                end
            end
            B_MUL_F:
            begin
                neg_reg  <= acc_f_reg[ACC_F_W-1];
                prod_reg <= prod_next;
            end
            B_HULL:
            begin
                hull_reg <= hull_next;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    stamp_out_reg <= stamp_reg;
                    mag_out_reg   <= mag_reg;
                    hull_out_reg  <= hull_reg;
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

endmodule
